### rtl/core/iha_pkg.sv
package iha_pkg;

	localparam int HEAP_GRANULES = 4095;
	localparam int GRANULE_BYTES = 16;
	localparam int GRAN_SHIFT    = 4;
	localparam int HEADER_BYTES  = 8;
	localparam int GADDR_W       = 12;

	localparam logic       CMD_ALLOC   = 1'b0;
	localparam logic       CMD_FREE    = 1'b1;
	localparam logic [1:0] ST_DONE     = 2'd0;
	localparam logic [1:0] ST_NOSPACE  = 2'd1;
	localparam logic [1:0] ST_BADFREE  = 2'd2;

	typedef logic [GADDR_W-1:0] gaddr_t;

	typedef struct packed {
		logic [GADDR_W-1:0] size;
		logic               alloc;
	} hdr_t;

	typedef struct packed {
		logic        command;
		logic [15:0] request_bytes;
		logic [15:0] payload_address;
	} req_t;

	typedef struct packed {
		logic [15:0] result_address;
		logic [1:0]  status;
	} rsp_t;

	// payload byte offset of the block starting at granule g
	function automatic logic [15:0] payload_of(input gaddr_t g);
		logic [GADDR_W-1:0] n;
		n = g + GADDR_W'(1);
		return {n, 4'h0};
	endfunction

endpackage

### rtl/core/implicit_list_heap_allocator.sv
// First-fit heap allocator over HEAP_GRANULES granules of 16 bytes, block
// headers held in one synchronous RAM (one read, one write port).
// req channel: command (allocate or free), request_bytes, payload_address.
// rsp channel: result_address and status, one rsp item for every req item.
// Both channels: an item moves on a clock edge with valid high, stall low.
// One request is worked on at a time; req_stall stays high from accept until
// the rsp item has been taken.
// Allocate: a merge pass walks every block header once, joining each run of
// free blocks into one block, then a first-fit walk reads headers from the
// bottom until a fit; with no fit the block goes at the heap top if there is
// room. Both walks read one header at a time through the header RAM read port.
// Free: walks headers up to the target block; an address that is null, not
// granule-aligned or beyond the heap top is answered without a walk.
// Reset clears the heap top and last-block pointer; the header RAM is not
// cleared, as every header is written before it is read.
// While rsp is stalled the result holds in its output register and no new
// request is taken.
module implicit_list_heap_allocator
	import iha_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MHDR  = 3'd1;
	localparam logic [2:0] S_MRUN  = 3'd2;
	localparam logic [2:0] S_FSTRT = 3'd3;
	localparam logic [2:0] S_AHDR  = 3'd4;
	localparam logic [2:0] S_SPLIT = 3'd5;
	localparam logic [2:0] S_EXT   = 3'd6;
	localparam logic [2:0] S_FREE  = 3'd7;

	logic [2:0]  state_q, state_d;
	logic [12:0] need_q, need_d;
	gaddr_t      target_q, target_d;
	gaddr_t      g_q, g_d;
	gaddr_t      end_q, end_d;
	gaddr_t      used_q, used_d;
	gaddr_t      last_q, last_d;
	gaddr_t      split_g_q, split_g_d;
	hdr_t        split_hdr_q, split_hdr_d;
	logic        rsp_valid_q, rsp_valid_d;
	rsp_t        rsp_q, rsp_d;

	logic        we;
	gaddr_t      waddr, raddr;
	hdr_t        wdata, rd;

	logic        accept;
	logic [12:0] gsum, esum, room, used13;
	logic [16:0] need_sum;
	gaddr_t      ftgt;

	iha_hdr_mem u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	assign req_stall = (state_q != S_IDLE) | rsp_valid_q;
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign used13   = {1'b0, used_q};
	assign gsum     = {1'b0, g_q} + {1'b0, rd.size};
	assign esum     = {1'b0, end_q} + {1'b0, rd.size};
	assign room     = 13'(HEAP_GRANULES) - used13;
	assign need_sum = {1'b0, req.request_bytes} + 17'(HEADER_BYTES + GRANULE_BYTES - 1);
	assign ftgt     = req.payload_address[15:GRAN_SHIFT] - GADDR_W'(1);

	always_comb begin
		state_d     = state_q;
		need_d      = need_q;
		target_d    = target_q;
		g_d         = g_q;
		end_d       = end_q;
		used_d      = used_q;
		last_d      = last_q;
		split_g_d   = split_g_q;
		split_hdr_d = split_hdr_q;
		rsp_valid_d = rsp_valid_q & rsp_stall;
		rsp_d       = rsp_q;
		we          = 1'b0;
		waddr       = g_q;
		wdata       = '0;
		raddr       = g_q;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					g_d   = '0;
					raddr = '0;
					if (req.command == CMD_ALLOC) begin
						need_d  = need_sum[16:GRAN_SHIFT];
						state_d = (used_q == '0) ? S_EXT : S_MHDR;
					end else if (req.payload_address == '0 ||
						req.payload_address[GRAN_SHIFT-1:0] != '0 || ftgt >= used_q) begin
						rsp_valid_d = 1'b1;
						rsp_d       = '{result_address: '0, status: ST_BADFREE};
					end else begin
						target_d = ftgt;
						state_d  = S_FREE;
					end
				end
			end
			S_MHDR: begin
				if (rd.size == '0) begin
					state_d = S_FSTRT;
				end else if (rd.alloc) begin
					g_d   = gsum[GADDR_W-1:0];
					raddr = gsum[GADDR_W-1:0];
					if (gsum >= used13) state_d = S_FSTRT;
				end else if (gsum >= used13) begin
					last_d  = g_q;
					state_d = S_FSTRT;
				end else begin
					end_d   = gsum[GADDR_W-1:0];
					raddr   = gsum[GADDR_W-1:0];
					state_d = S_MRUN;
				end
			end
			S_MRUN: begin
				we    = 1'b1;
				waddr = g_q;
				if (!rd.alloc && rd.size != '0) begin
					if (esum >= used13) begin
						wdata   = '{size: esum[GADDR_W-1:0] - g_q, alloc: 1'b0};
						last_d  = g_q;
						state_d = S_FSTRT;
					end else begin
						we    = 1'b0;
						end_d = esum[GADDR_W-1:0];
						raddr = esum[GADDR_W-1:0];
					end
				end else begin
					// run ends at a used block: close it, re-read that header
					wdata   = '{size: end_q - g_q, alloc: 1'b0};
					g_d     = end_q;
					raddr   = end_q;
					state_d = S_MHDR;
				end
			end
			S_FSTRT: begin
				g_d     = '0;
				raddr   = '0;
				state_d = S_AHDR;
			end
			S_AHDR: begin
				if (rd.size == '0) begin
					state_d = S_EXT;
				end else if (!rd.alloc && {1'b0, rd.size} >= need_q) begin
					we    = 1'b1;
					waddr = g_q;
					rsp_d = '{result_address: payload_of(g_q), status: ST_DONE};
					if ({1'b0, rd.size} > need_q) begin
						wdata       = '{size: need_q[GADDR_W-1:0], alloc: 1'b1};
						split_g_d   = g_q + need_q[GADDR_W-1:0];
						split_hdr_d = '{size: rd.size - need_q[GADDR_W-1:0], alloc: 1'b0};
						if (last_q == g_q) last_d = g_q + need_q[GADDR_W-1:0];
						state_d     = S_SPLIT;
					end else begin
						wdata       = '{size: rd.size, alloc: 1'b1};
						rsp_valid_d = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					g_d   = gsum[GADDR_W-1:0];
					raddr = gsum[GADDR_W-1:0];
					if (gsum >= used13) state_d = S_EXT;
				end
			end
			S_SPLIT: begin
				we          = 1'b1;
				waddr       = split_g_q;
				wdata       = split_hdr_q;
				rsp_valid_d = 1'b1;
				state_d     = S_IDLE;
			end
			S_EXT: begin
				rsp_valid_d = 1'b1;
				state_d     = S_IDLE;
				if (need_q > room) begin
					rsp_d = '{result_address: '0, status: ST_NOSPACE};
				end else begin
					we     = 1'b1;
					waddr  = used_q;
					wdata  = '{size: need_q[GADDR_W-1:0], alloc: 1'b1};
					last_d = used_q;
					used_d = used_q + need_q[GADDR_W-1:0];
					rsp_d  = '{result_address: payload_of(used_q), status: ST_DONE};
				end
			end
			S_FREE: begin
				if (g_q == target_q) begin
					we          = 1'b1;
					waddr       = g_q;
					wdata       = '{size: rd.size, alloc: 1'b0};
					rsp_valid_d = 1'b1;
					rsp_d       = '{result_address: '0, status: ST_DONE};
					state_d     = S_IDLE;
				end else if (rd.size == '0 || g_q > target_q || gsum >= used13) begin
					rsp_valid_d = 1'b1;
					rsp_d       = '{result_address: '0, status: ST_BADFREE};
					state_d     = S_IDLE;
				end else begin
					g_d   = gsum[GADDR_W-1:0];
					raddr = gsum[GADDR_W-1:0];
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			last_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			used_q      <= used_d;
			last_q      <= last_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		need_q      <= need_d;
		target_q    <= target_d;
		g_q         <= g_d;
		end_q       <= end_d;
		split_g_q   <= split_g_d;
		split_hdr_q <= split_hdr_d;
		rsp_q       <= rsp_d;
	end

	a_no_accept_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> !rsp_valid)
		else $error("request taken while a result is pending");

	a_rsp_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> state_q == S_IDLE)
		else $error("result raised while still walking headers");

	a_last_below_top: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != '0) |-> last_q < used_q)
		else $error("last block pointer beyond heap top");

	a_top_grows_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXT) |=> used_q == $past(used_q))
		else $error("heap top moved outside extension");

endmodule

### rtl/core/iha_hdr_mem.sv
module iha_hdr_mem
	import iha_pkg::*;
(
	input  logic   clk,
	input  logic   we,
	input  gaddr_t waddr,
	input  hdr_t   wdata,
	input  gaddr_t raddr,
	output hdr_t   rdata
);

	hdr_t mem [HEAP_GRANULES];
	hdr_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
